### hw/rtl/voxel_face_mesher_defines.svh
// Assertion macros shared by the voxel face mesher checker.
`ifndef VOXEL_FACE_MESHER_DEFINES_SVH
`define VOXEL_FACE_MESHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define VFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define VFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/vfm_pkg.sv
// Package with types, constants and tables for the voxel face mesher.
package vfm_pkg;
    localparam int SizeX = 16;
    localparam int SizeY = 16;
    localparam int SizeZ = 16;
    localparam int CW = 4;
    localparam int AW = 3 * CW;
    localparam int QDepth = 4;
    localparam int QAW = $clog2(QDepth);

    typedef enum logic [1:0] {
        REQ_VOXEL   = 2'd0,
        REQ_PALETTE = 2'd1,
        REQ_MESH    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [3:0] pos_z;
        logic [7:0] voxel_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_word;

    typedef struct packed {
        logic [4:0] vert_x;
        logic [4:0] vert_y;
        logic [4:0] vert_z;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] light;
        logic [2:0] normal;
        logic       last;
    } t_out_word;

    typedef struct packed {
        t_req       req;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic [7:0] vt;
        logic [23:0] col;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CENTER, S_NBR, S_FACE, S_LREAD, S_LWAIT, S_EMIT
    } t_state;

    function automatic logic [2:0] face_norm(input logic [2:0] f);
        case (f)
            3'd0: face_norm = 3'd2;
            3'd1: face_norm = 3'd3;
            3'd2: face_norm = 3'd0;
            3'd3: face_norm = 3'd1;
            3'd4: face_norm = 3'd4;
            default: face_norm = 3'd5;
        endcase
    endfunction

    // Corner offsets as {dx, dy, dz} for face f and vertex v.
    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [2:0] v);
        logic [17:0] row;
        row = 18'd0;
        case (f)
            3'd0: row = {3'b110, 3'b101, 3'b100, 3'b111, 3'b101, 3'b110};
            3'd1: row = {3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011};
            3'd2: row = {3'b011, 3'b110, 3'b010, 3'b111, 3'b110, 3'b011};
            3'd3: row = {3'b000, 3'b100, 3'b001, 3'b001, 3'b100, 3'b101};
            3'd4: row = {3'b111, 3'b011, 3'b001, 3'b001, 3'b101, 3'b111};
            default: row = {3'b000, 3'b010, 3'b110, 3'b110, 3'b100, 3'b000};
        endcase
        case (v)
            3'd0: face_corner = row[17:15];
            3'd1: face_corner = row[14:12];
            3'd2: face_corner = row[11:9];
            3'd3: face_corner = row[8:6];
            3'd4: face_corner = row[5:3];
            default: face_corner = row[2:0];
        endcase
    endfunction

    function automatic logic [7:0] light_lut(input logic [2:0] n);
        case (n)
            3'd0: light_lut = 8'd0;
            3'd1: light_lut = 8'd42;
            3'd2: light_lut = 8'd85;
            3'd3: light_lut = 8'd127;
            3'd4: light_lut = 8'd170;
            3'd5: light_lut = 8'd212;
            default: light_lut = 8'd255;
        endcase
    endfunction

    // Neighbor step in direction d; o is set when it leaves the grid.
    function automatic logic [AW:0] step(input logic [3:0] x, input logic [3:0] y,
                                         input logic [3:0] z, input logic [2:0] d);
        logic [3:0] nx, ny, nz;
        logic o;
        nx = x; ny = y; nz = z; o = 1'b0;
        case (d)
            3'd0: begin nx = x + 4'd1; o = (x == 4'(SizeX - 1)); end
            3'd1: begin nx = x - 4'd1; o = (x == 4'd0); end
            3'd2: begin ny = y + 4'd1; o = (y == 4'(SizeY - 1)); end
            3'd3: begin ny = y - 4'd1; o = (y == 4'd0); end
            3'd4: begin nz = z + 4'd1; o = (z == 4'(SizeZ - 1)); end
            default: begin nz = z - 4'd1; o = (z == 4'd0); end
        endcase
        step = {o, nz, ny, nx};
    endfunction
endpackage

### hw/rtl/voxel_face_mesher.sv
// Top level of the voxel face mesher: a four-entry request queue feeding the meshing engine.
// A word is accepted in any cycle the queue has room; writes reach the store once the idle engine takes them.
// A mesh request reads its voxel and six neighbors, then per open face reads the cells around
// that neighbor for its light (none at the grid edge) and emits six vertices.
// The vertices of a face leave one per cycle while the output is not stalled by i_ready.
// Reset is synchronous and active low; a clearing pass then zeroes the block store.
module voxel_face_mesher
    import vfm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    logic cmd_v, cmd_r;
    t_cmd cmd;

    vfm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word(i_data),
        .o_cmd_valid(cmd_v), .i_cmd_ready(cmd_r), .o_cmd(cmd)
    );

    vfm_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_v), .o_cmd_ready(cmd_r), .i_cmd(cmd),
        .o_valid, .i_ready, .o_word(o_data)
    );
endmodule

### hw/rtl/vfm_front.sv
// Front part: accepts request words, drops REQ_NONE words and queues commands.
module vfm_front
    import vfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);
    t_cmd r_q [QDepth];
    logic [QAW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [QAW:0] r_cnt, n_cnt;
    logic take, push, pop;

    assign o_ready = (r_cnt != (QAW+1)'(QDepth));
    assign take = i_valid && o_ready;
    assign push = take && (i_word.req_type != REQ_NONE);
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        n_wp = push ? r_wp + 1'b1 : r_wp;
        n_rp = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{req: t_req'(i_word.req_type), x: i_word.pos_x, y: i_word.pos_y,
                           z: i_word.pos_z, vt: i_word.voxel_type,
                           col: {i_word.red_in, i_word.green_in, i_word.blue_in}};
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

### hw/rtl/vfm_back.sv
// Back part: holds the block store and palette, culls faces and emits vertex words.
module vfm_back
    import vfm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);
    logic [7:0] r_mem [1 << AW];
    logic [7:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic wr_en;
    logic [7:0] wr_data;
    logic [23:0] r_pal [256];
    logic [23:0] r_pal_q;
    logic pal_wr_en;

    t_state r_st, n_st;
    t_cmd r_c, n_c;
    logic [AW-1:0] r_clr, n_clr;
    logic [2:0] r_f, n_f;
    logic [2:0] r_d, n_d;
    logic [2:0] r_v, n_v;
    logic [2:0] r_cnt, n_cnt;
    logic [5:0] r_open, n_open;
    logic [7:0] r_lt, n_lt;
    logic [23:0] r_col, n_col;
    logic r_ov, n_ov;
    t_out_word r_ow, n_ow;
    logic [AW:0] nb, nb_next, nn, nn_first, nn_next;
    logic [2:0] corner;
    logic out_free, more;

    assign nb = step(r_c.x, r_c.y, r_c.z, r_f);
    assign nb_next = step(r_c.x, r_c.y, r_c.z, r_f + 3'd1);
    assign nn = step(nb[CW-1:0], nb[2*CW-1:CW], nb[AW-1:2*CW], r_d);
    assign nn_first = step(nb[CW-1:0], nb[2*CW-1:CW], nb[AW-1:2*CW], 3'd0);
    assign nn_next = step(nb[CW-1:0], nb[2*CW-1:CW], nb[AW-1:2*CW], r_d + 3'd1);
    assign corner = face_corner(r_f, r_v);
    assign out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_word = r_ow;

    always_comb begin
        more = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (3'(k) > r_f && r_open[k]) more = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st; n_c = r_c; n_clr = r_clr; n_f = r_f; n_d = r_d; n_v = r_v;
        n_cnt = r_cnt; n_open = r_open; n_lt = r_lt; n_col = r_col;
        n_ov = r_ov && !i_ready; n_ow = r_ow;
        o_cmd_ready = 1'b0;
        rd_addr = nb[AW-1:0];
        wr_addr = r_clr; wr_en = 1'b0; wr_data = 8'd0;
        pal_wr_en = 1'b0;
        case (r_st)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) n_st = S_IDLE;
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                rd_addr = {i_cmd.z, i_cmd.y, i_cmd.x};
                if (i_cmd_valid) begin
                    n_c = i_cmd;
                    case (i_cmd.req)
                        REQ_VOXEL: begin
                            wr_en = 1'b1;
                            wr_addr = {i_cmd.z, i_cmd.y, i_cmd.x};
                            wr_data = i_cmd.vt;
                        end
                        REQ_PALETTE: begin
                            pal_wr_en = 1'b1;
                        end
                        REQ_MESH: begin
                            n_st = S_CENTER;
                            n_f = 3'd0;
                            n_open = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CENTER: begin
                if (r_rd == 8'd0) begin
                    n_st = S_IDLE;
                end else begin
                    n_st = S_NBR;
                end
            end
            S_NBR: begin
                if (r_f == 3'd0) n_col = r_pal_q;
                n_open[r_f] = nb[AW] || (r_rd == 8'd0);
                rd_addr = nb_next[AW-1:0];
                if (r_f == 3'd5) begin
                    n_f = 3'd0;
                    n_st = S_FACE;
                end else begin
                    n_f = r_f + 3'd1;
                end
            end
            S_FACE: begin
                if (r_open == '0) begin
                    n_st = S_IDLE;
                end else if (!r_open[r_f]) begin
                    n_f = r_f + 3'd1;
                end else if (nb[AW]) begin
                    n_lt = 8'd255; n_v = 3'd0; n_st = S_EMIT;
                end else begin
                    n_d = 3'd0; n_cnt = 3'd0;
                    rd_addr = nn_first[AW-1:0];
                    n_st = S_LREAD;
                end
            end
            S_LREAD: begin
                if (nn[AW] || r_rd == 8'd0) n_cnt = r_cnt + 3'd1;
                if (r_d == 3'd5) begin
                    n_st = S_LWAIT;
                end else begin
                    n_d = r_d + 3'd1;
                    rd_addr = nn_next[AW-1:0];
                end
            end
            S_LWAIT: begin
                n_lt = light_lut(r_cnt);
                n_v = 3'd0;
                n_st = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ow.vert_x = 5'(r_c.x) + 5'(corner[2]);
                    n_ow.vert_y = 5'(r_c.y) + 5'(corner[1]);
                    n_ow.vert_z = 5'(r_c.z) + 5'(corner[0]);
                    n_ow.red_out = r_col[23:16];
                    n_ow.green_out = r_col[15:8];
                    n_ow.blue_out = r_col[7:0];
                    n_ow.light = r_lt;
                    n_ow.normal = face_norm(r_f);
                    n_ow.last = (r_v == 3'd5) && !more;
                    if (r_v == 3'd5) begin
                        if (more) begin
                            n_f = r_f + 3'd1;
                            n_st = S_FACE;
                        end else begin
                            n_st = S_IDLE;
                        end
                    end else begin
                        n_v = r_v + 3'd1;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pal_wr_en) r_pal[i_cmd.vt] <= i_cmd.col;
        r_pal_q <= r_pal[r_rd];
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c; r_f <= n_f; r_d <= n_d; r_v <= n_v; r_cnt <= n_cnt;
        r_open <= n_open; r_lt <= n_lt; r_ow <= n_ow; r_col <= n_col;
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_clr <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_clr <= n_clr;
            r_ov <= n_ov;
        end
    end
endmodule

### hw/rtl/vfm_checker.sv
// Port-level checker for the voxel face mesher, bound to the top level.
`include "voxel_face_mesher_defines.svh"
module vfm_checker
    import vfm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);
    `VFM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `VFM_ASSERT_IMPL(a_norm, i_clk, i_rst_n, o_valid, o_data.normal <= 3'd5)
    `VFM_ASSERT_IMPL(a_vx, i_clk, i_rst_n, o_valid, o_data.vert_x <= 5'd16)
    `VFM_ASSERT_IMPL(a_vy, i_clk, i_rst_n, o_valid, o_data.vert_y <= 5'd16)
endmodule

bind voxel_face_mesher vfm_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);

### test/tb.sv
// Testbench for the voxel face mesher: directed table, random traffic and a vertex scoreboard.
`timescale 1ns / 100ps

module tb;
    import vfm_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    voxel_face_mesher u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    localparam int CycleLimit = 2000000;

    typedef struct {
        t_in_word  word;
        bit        has_ref;
        t_out_word ref_first;
    } t_row;

    logic [7:0]  grid_model [0:4095];
    logic [23:0] color_model [0:255];
    bit          color_written [0:255];
    t_out_word   vertex_queue [$];
    t_row        rows [$];

    int  n_errors;
    int  n_vertices;
    int  n_meshes;
    int  cycle_count;
    bit  stall_long;
    bit  flagged_first;
    t_out_word pinned_first;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic bit is_inside(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < SizeX && y < SizeY && z < SizeZ;
    endfunction

    function automatic logic [7:0] grid_at(int x, int y, int z);
        return grid_model[x + y * SizeX + z * SizeX * SizeY];
    endfunction

    function automatic bit is_open(int x, int y, int z);
        if (!is_inside(x, y, z)) return 1'b1;
        return grid_at(x, y, z) == 8'd0;
    endfunction

    function automatic int dir_of(int f, int axis);
        int d;
        d = 0;
        if (f / 2 == axis) d = (f % 2 == 0) ? 1 : -1;
        return d;
    endfunction

    function automatic logic [7:0] cell_light(int x, int y, int z);
        int n;
        n = 0;
        if (!is_inside(x, y, z)) return 8'd255;
        if (grid_at(x, y, z) != 8'd0) return 8'd0;
        for (int f = 0; f < 6; f++)
            if (is_open(x + dir_of(f, 0), y + dir_of(f, 1), z + dir_of(f, 2))) n++;
        return 8'(n * 255 / 6);
    endfunction

    task automatic apply_request(input t_in_word w);
        int x, y, z, k;
        logic [2:0] nrm [0:5];
        logic [2:0] corner [0:5][0:5];
        logic [7:0] vt, lt;
        logic [23:0] col;
        t_out_word v;
        nrm = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5};
        corner = '{
            '{3'b110, 3'b101, 3'b100, 3'b111, 3'b101, 3'b110},
            '{3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011},
            '{3'b011, 3'b110, 3'b010, 3'b111, 3'b110, 3'b011},
            '{3'b000, 3'b100, 3'b001, 3'b001, 3'b100, 3'b101},
            '{3'b111, 3'b011, 3'b001, 3'b001, 3'b101, 3'b111},
            '{3'b000, 3'b010, 3'b110, 3'b110, 3'b100, 3'b000}};
        x = w.pos_x;
        y = w.pos_y;
        z = w.pos_z;
        k = 0;
        case (t_req'(w.req_type))
            REQ_VOXEL: grid_model[x + y * SizeX + z * SizeX * SizeY] = w.voxel_type;
            REQ_PALETTE: begin
                color_model[w.voxel_type] = {w.red_in, w.green_in, w.blue_in};
                color_written[w.voxel_type] = 1'b1;
            end
            REQ_MESH: begin
                vt = grid_at(x, y, z);
                if (vt != 8'd0) begin
                    n_meshes++;
                    col = color_model[vt];
                    for (int f = 0; f < 6; f++) begin
                        if (is_open(x + dir_of(f, 0), y + dir_of(f, 1), z + dir_of(f, 2))) begin
                            lt = cell_light(x + dir_of(f, 0), y + dir_of(f, 1), z + dir_of(f, 2));
                            for (int c = 0; c < 6; c++) begin
                                v.vert_x = 5'(x + corner[f][c][2]);
                                v.vert_y = 5'(y + corner[f][c][1]);
                                v.vert_z = 5'(z + corner[f][c][0]);
                                v.red_out = col[23:16];
                                v.green_out = col[15:8];
                                v.blue_out = col[7:0];
                                v.light = lt;
                                v.normal = nrm[f];
                                v.last = 1'b0;
                                vertex_queue.push_back(v);
                                k++;
                            end
                        end
                    end
                    if (k > 0) vertex_queue[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in_word make_word(t_req r, int x, int y, int z, int vt, int rgb);
        t_in_word w;
        w.req_type = r;
        w.pos_x = 4'(x);
        w.pos_y = 4'(y);
        w.pos_z = 4'(z);
        w.voxel_type = 8'(vt);
        w.red_in = 8'(rgb >> 16);
        w.green_in = 8'(rgb >> 8);
        w.blue_in = 8'(rgb);
        return w;
    endfunction

    task automatic add_row(input t_in_word w);
        t_row r;
        r.word = w;
        r.has_ref = 1'b0;
        r.ref_first = '0;
        rows.push_back(r);
    endtask

    // Lone voxel at the origin: first vertex is the x+ face, whose neighbor has five open sides.
    task automatic build_table();
        t_row r;
        add_row(make_word(REQ_PALETTE, 0, 0, 0, 1, 24'hFFFFFF));
        add_row(make_word(REQ_PALETTE, 15, 15, 15, 255, 24'h000000));
        add_row(make_word(REQ_PALETTE, 5, 10, 3, 128, 24'hA55A0F));
        add_row(make_word(REQ_VOXEL, 0, 0, 0, 1, 0));
        r.word = make_word(REQ_MESH, 0, 0, 0, 0, 0);
        r.has_ref = 1'b1;
        r.ref_first = '{5'd1, 5'd1, 5'd0, 8'hFF, 8'hFF, 8'hFF, 8'd212, 3'd2, 1'b0};
        rows.push_back(r);
        add_row(make_word(REQ_VOXEL, 15, 15, 15, 255, 0));
        add_row(make_word(REQ_MESH, 15, 15, 15, 0, 0));
        add_row(make_word(REQ_VOXEL, 1, 0, 0, 128, 0));
        add_row(make_word(REQ_MESH, 0, 0, 0, 0, 0));
        add_row(make_word(REQ_MESH, 1, 0, 0, 0, 0));
        add_row(make_word(REQ_MESH, 7, 7, 7, 0, 0));
        add_row(make_word(REQ_NONE, 7, 7, 7, 255, 24'hFFFFFF));
        add_row(make_word(REQ_VOXEL, 8, 8, 8, 128, 0));
        add_row(make_word(REQ_VOXEL, 9, 8, 8, 1, 0));
        add_row(make_word(REQ_VOXEL, 8, 9, 8, 1, 0));
        add_row(make_word(REQ_VOXEL, 8, 8, 9, 1, 0));
        add_row(make_word(REQ_MESH, 8, 8, 8, 0, 0));
        add_row(make_word(REQ_MESH, 9, 8, 8, 0, 0));
        add_row(make_word(REQ_VOXEL, 9, 8, 8, 0, 0));
        add_row(make_word(REQ_MESH, 8, 8, 8, 0, 0));
    endtask

    function automatic t_in_word random_word();
        int pick, vt;
        logic [63:0] raw;
        t_in_word w;
        raw = {$urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        pick = $urandom_range(0, 99);
        w.pos_x = 4'($urandom_range(4, 7));
        w.pos_y = 4'($urandom_range(4, 7));
        w.pos_z = 4'($urandom_range(4, 7));
        if (pick < 8) begin
            w.pos_x = 4'($urandom);
            w.pos_y = 4'($urandom);
            w.pos_z = 4'($urandom);
        end
        if (pick < 40) begin
            w.req_type = REQ_VOXEL;
            vt = $urandom_range(0, 255);
            if (!color_written[vt] || $urandom_range(0, 3) == 0) vt = 0;
            w.voxel_type = 8'(vt);
        end else if (pick < 50) begin
            w.req_type = REQ_PALETTE;
        end else if (pick < 97) begin
            w.req_type = REQ_MESH;
        end else begin
            w.req_type = REQ_NONE;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!o_ready);
        apply_request(w);
    endtask

    task automatic random_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_long) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 7) < ((cycle_count / 512) % 2 == 0 ? 7 : 4));
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (vertex_queue.size() == 0) begin
                $error("vertex with none expected: %p", o_data);
                n_errors++;
            end else begin
                e = vertex_queue.pop_front();
                n_vertices++;
                if (flagged_first) begin
                    if (o_data !== pinned_first) begin
                        $error("pinned vertex: expected %p actual %p", pinned_first, o_data);
                        n_errors++;
                    end
                    flagged_first = 1'b0;
                end
                if (o_data.vert_x !== e.vert_x) begin
                    $error("vert_x: expected %0d actual %0d", e.vert_x, o_data.vert_x);
                    n_errors++;
                end
                if (o_data.vert_y !== e.vert_y) begin
                    $error("vert_y: expected %0d actual %0d", e.vert_y, o_data.vert_y);
                    n_errors++;
                end
                if (o_data.vert_z !== e.vert_z) begin
                    $error("vert_z: expected %0d actual %0d", e.vert_z, o_data.vert_z);
                    n_errors++;
                end
                if (o_data.red_out !== e.red_out) begin
                    $error("red_out: expected %0d actual %0d", e.red_out, o_data.red_out);
                    n_errors++;
                end
                if (o_data.green_out !== e.green_out) begin
                    $error("green_out: expected %0d actual %0d", e.green_out, o_data.green_out);
                    n_errors++;
                end
                if (o_data.blue_out !== e.blue_out) begin
                    $error("blue_out: expected %0d actual %0d", e.blue_out, o_data.blue_out);
                    n_errors++;
                end
                if (o_data.light !== e.light) begin
                    $error("light: expected %0d actual %0d", e.light, o_data.light);
                    n_errors++;
                end
                if (o_data.normal !== e.normal) begin
                    $error("normal: expected %0d actual %0d", e.normal, o_data.normal);
                    n_errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last: expected %0d actual %0d", e.last, o_data.last);
                    n_errors++;
                end
            end
        end
        if (cycle_count >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int burst;
        t_in_word w;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        stall_long = 1'b0;
        flagged_first = 1'b0;
        n_errors = 0;
        n_vertices = 0;
        n_meshes = 0;
        cycle_count = 0;
        for (int i = 0; i < 4096; i++) grid_model[i] = 8'd0;
        for (int i = 0; i < 256; i++) begin
            color_model[i] = 24'd0;
            color_written[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        build_table();
        foreach (rows[i]) begin
            if (rows[i].has_ref) begin
                drain_results();
                pinned_first = rows[i].ref_first;
                flagged_first = 1'b1;
            end
            send_word(rows[i].word);
            random_gap();
        end
        drain_results();

        // A dense block of filled voxels gives varied open faces and light.
        for (int i = 0; i < 16; i++)
            send_word(make_word(REQ_PALETTE, 0, 0, 0, i, $urandom));
        for (int i = 16; i < 256; i++) color_written[i] = 1'b0;
        for (int i = 0; i < 16; i++) color_written[i] = 1'b1;

        for (int i = 0; i < 250; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && i < 250; j++) begin
                w = random_word();
                if (w.req_type == REQ_PALETTE) begin
                    color_written[w.voxel_type] = 1'b1;
                end
                send_word(w);
                i++;
                if (i == 120) begin
                    stall_long <= 1'b1;
                    fork
                        begin
                            repeat (400) @(posedge i_clk);
                            stall_long <= 1'b0;
                        end
                    join_none
                end
                if (i == 200) drain_results();
            end
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        drain_results();

        $display("Covered %0d mesh requests producing %0d vertices, with bursts, stalls and drains.",
                 n_meshes, n_vertices);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vfm_pkg.sv
hw/rtl/vfm_front.sv
hw/rtl/vfm_back.sv
hw/rtl/voxel_face_mesher.sv
hw/rtl/vfm_checker.sv
test/tb.sv
